[src/iffp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iffp_pkg
// Shared types and constants of the script chunk parser.
// ----------------------------------------------------------------------------
`default_nettype none
package iffp_pkg;

    localparam logic [31:0] ID_FORM = 32'h464F524D;
    localparam logic [31:0] ID_TEXT = 32'h54455854;
    localparam logic [31:0] ID_DATA = 32'h44415441;
    localparam logic [31:0] ID_EMC2 = 32'h454D4332;
    localparam logic [31:0] ID_ORDR = 32'h4F524452;

    typedef enum logic [2:0] {
        PH_ID   = 3'd0,
        PH_EXT  = 3'd1,
        PH_SIZE = 3'd2,
        PH_FORM = 3'd3,
        PH_PAY  = 3'd4,
        PH_ERR  = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        KIND_TEXT = 2'd0,
        KIND_DATA = 2'd1,
        KIND_ORDR = 2'd2
    } t_kind;

    localparam logic [2:0] RG_ID    = 3'd0;
    localparam logic [2:0] RG_EXT   = 3'd1;
    localparam logic [2:0] RG_SIZE  = 3'd2;
    localparam logic [2:0] RG_FORM  = 3'd3;
    localparam logic [2:0] RG_TEXT  = 3'd4;
    localparam logic [2:0] RG_DATA  = 3'd5;
    localparam logic [2:0] RG_ORDR  = 3'd6;
    localparam logic [2:0] RG_ERR   = 3'd7;

    // Classified byte handed from the front to the back.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [2:0]  region;
        logic        pay_even;   // payload byte at even offset (word high)
        logic        pay_odd;    // payload byte at odd offset (word low)
        logic        text;       // payload belongs to a text chunk
        logic [31:0] pidx;
        logic        ended;
        logic        err;
        logic        text_new;   // text size was loaded on this byte
        logic        ordr_new;   // order size was loaded on this byte
        logic [31:0] size;       // size (padded to even for text) when text_new / ordr_new
    } t_item;

    // Result as held in the result register.
    typedef struct packed {
        logic [2:0]  region;
        logic [31:0] pidx;
        logic        wvalid;
        logic [15:0] wvalue;
        logic [30:0] windex;
        logic [31:0] text_bytes;
        logic [30:0] strings;
        logic [30:0] funcs;
        logic        clean_end;
    } t_result;

endpackage
`default_nettype wire

[src/iffp_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iffp_front
// Chunk framing: id match, size capture and payload counting per byte.
// ----------------------------------------------------------------------------
`default_nettype none
module iffp_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire logic [7:0]     i_data,
    input  wire logic           i_last,
    output iffp_pkg::t_item     o_item
);

    iffp_pkg::t_phase r_phase, n_phase;
    iffp_pkg::t_kind  r_kind, n_kind;
    logic [31:0] r_id, n_id;
    logic [31:0] r_size, n_size;
    logic [31:0] r_left, n_left;
    logic [31:0] r_pos, n_pos;
    logic [1:0]  r_cnt, n_cnt;
    logic        r_pre, n_pre;
    logic        r_err, n_err;
    logic [31:0] w_sz;
    logic        w_full;

    always_comb begin
        n_phase = r_phase;
        n_kind  = r_kind;
        n_id    = r_id;
        n_size  = r_size;
        n_left  = r_left;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_pre   = r_pre;
        n_err   = r_err;
        w_full  = (r_cnt == 2'd3);
        w_sz    = {r_size[23:0], i_data};
        o_item  = '0;
        o_item.data = i_data;
        o_item.last = i_last;
        o_item.region = iffp_pkg::RG_ERR;
        unique case (r_phase)
            iffp_pkg::PH_ID: begin
                o_item.region = iffp_pkg::RG_ID;
                n_id  = {r_id[23:0], i_data};
                n_cnt = r_cnt + 2'd1;
                if (w_full) begin
                    if (n_id == iffp_pkg::ID_FORM) begin
                        n_phase = iffp_pkg::PH_FORM;
                    end else if (n_id == iffp_pkg::ID_TEXT) begin
                        n_kind  = iffp_pkg::KIND_TEXT;
                        n_phase = iffp_pkg::PH_SIZE;
                    end else if (n_id == iffp_pkg::ID_DATA) begin
                        n_kind  = iffp_pkg::KIND_DATA;
                        n_phase = iffp_pkg::PH_SIZE;
                    end else begin
                        n_pre   = (n_id == iffp_pkg::ID_EMC2);
                        n_phase = iffp_pkg::PH_EXT;
                    end
                end
            end
            iffp_pkg::PH_EXT: begin
                o_item.region = iffp_pkg::RG_EXT;
                n_id  = {r_id[23:0], i_data};
                n_cnt = r_cnt + 2'd1;
                if (w_full) begin
                    if (r_pre && n_id == iffp_pkg::ID_ORDR) begin
                        n_kind  = iffp_pkg::KIND_ORDR;
                        n_phase = iffp_pkg::PH_SIZE;
                    end else begin
                        o_item.region = iffp_pkg::RG_ERR;
                        n_err   = 1'b1;
                        n_phase = iffp_pkg::PH_ERR;
                    end
                end
            end
            iffp_pkg::PH_FORM: begin
                o_item.region = iffp_pkg::RG_FORM;
                n_cnt = r_cnt + 2'd1;
                if (w_full) begin
                    n_phase = iffp_pkg::PH_ID;
                    o_item.ended = 1'b1;
                end
            end
            iffp_pkg::PH_SIZE: begin
                o_item.region = iffp_pkg::RG_SIZE;
                n_size = w_sz;
                n_cnt  = r_cnt + 2'd1;
                if (w_full) begin
                    if (r_kind == iffp_pkg::KIND_TEXT) begin
                        w_sz = w_sz + {31'd0, w_sz[0]};
                        o_item.text_new = 1'b1;
                    end else if (r_kind == iffp_pkg::KIND_ORDR) begin
                        o_item.ordr_new = 1'b1;
                    end
                    o_item.size = w_sz;
                    n_left = w_sz;
                    n_pos  = '0;
                    if (w_sz == 32'd0) begin
                        n_phase = iffp_pkg::PH_ID;
                        o_item.ended = 1'b1;
                    end else begin
                        n_phase = iffp_pkg::PH_PAY;
                    end
                end
            end
            iffp_pkg::PH_PAY: begin
                unique case (r_kind)
                    iffp_pkg::KIND_TEXT: o_item.region = iffp_pkg::RG_TEXT;
                    iffp_pkg::KIND_DATA: o_item.region = iffp_pkg::RG_DATA;
                    default:             o_item.region = iffp_pkg::RG_ORDR;
                endcase
                o_item.pidx = r_pos;
                o_item.text = (r_kind == iffp_pkg::KIND_TEXT);
                if (r_kind != iffp_pkg::KIND_DATA) begin
                    o_item.pay_even = ~r_pos[0];
                    o_item.pay_odd  = r_pos[0];
                end
                n_pos  = r_pos + 32'd1;
                n_left = r_left - 32'd1;
                if (n_left == 32'd0) begin
                    n_phase = iffp_pkg::PH_ID;
                    o_item.ended = 1'b1;
                end
            end
            default: begin
                n_err   = 1'b1;
                n_phase = iffp_pkg::PH_ERR;
            end
        endcase
        o_item.err = n_err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && i_last)) begin
            r_phase <= iffp_pkg::PH_ID;
            r_kind  <= iffp_pkg::KIND_TEXT;
            r_id    <= '0;
            r_size  <= '0;
            r_left  <= '0;
            r_pos   <= '0;
            r_cnt   <= '0;
            r_pre   <= 1'b0;
            r_err   <= 1'b0;
        end else if (i_valid) begin
            r_phase <= n_phase;
            r_kind  <= n_kind;
            r_id    <= n_id;
            r_size  <= n_size;
            r_left  <= n_left;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_pre   <= n_pre;
            r_err   <= n_err;
        end
    end

endmodule
`default_nettype wire

[src/iffp_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iffp_queue
// Two-entry queue of classified bytes between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module iffp_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire iffp_pkg::t_item i_item,
    output logic                o_full,
    input  wire logic           i_pop,
    output logic                o_empty,
    output iffp_pkg::t_item     o_item
);

    iffp_pkg::t_item r_mem [2];
    logic        r_wp, r_rp;
    logic [1:0]  r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push && !o_full) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && !o_empty) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push && !o_full} - {1'b0, i_pop && !o_empty};
        end
    end

endmodule
`default_nettype wire

[src/iffp_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iffp_back
// Word assembly, string and function counting and result register.
// ----------------------------------------------------------------------------
`default_nettype none
module iffp_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire iffp_pkg::t_item i_item,
    output logic                 o_take,
    output logic                 o_empty,
    input  wire logic            i_pop,
    output iffp_pkg::t_result    o_res
);

    logic [7:0]  r_high;
    logic [31:0] r_tsize;
    logic [30:0] r_strings;
    logic        r_done;
    logic [30:0] r_funcs;
    logic        r_full;
    iffp_pkg::t_result r_res;
    iffp_pkg::t_result n_res;
    logic [31:0] n_tsize;
    logic [30:0] n_strings;
    logic        n_done;
    logic [30:0] n_funcs;
    logic [15:0] w_word;

    assign o_take  = i_valid && (!r_full || i_pop);
    assign o_empty = !r_full;
    assign o_res   = r_res;
    assign w_word  = {r_high, i_item.data};

    always_comb begin
        n_tsize   = r_tsize;
        n_strings = r_strings;
        n_done    = r_done;
        n_funcs   = r_funcs;
        if (i_item.text_new) begin
            n_tsize   = i_item.size;
            n_strings = '0;
            n_done    = 1'b0;
        end
        if (i_item.ordr_new) begin
            n_funcs = i_item.size[31:1];
        end
        n_res = '0;
        n_res.region = i_item.region;
        n_res.pidx   = i_item.pidx;
        if (i_item.pay_odd) begin
            n_res.wvalid = 1'b1;
            n_res.wvalue = w_word;
            n_res.windex = i_item.pidx[31:1];
            if (i_item.text && !r_done) begin
                if ({16'd0, w_word} >= r_tsize) begin
                    n_done = 1'b1;
                end else begin
                    n_strings = r_strings + 31'd1;
                end
            end
        end
        n_res.text_bytes = n_tsize;
        n_res.strings    = n_strings;
        n_res.funcs      = n_funcs;
        n_res.clean_end  = i_item.last && i_item.ended && !i_item.err;
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_res <= n_res;
            if (i_item.pay_even) begin
                r_high <= i_item.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full    <= 1'b0;
            r_tsize   <= '0;
            r_strings <= '0;
            r_done    <= 1'b0;
            r_funcs   <= '0;
        end else begin
            if (o_take) begin
                r_full <= 1'b1;
            end else if (i_pop) begin
                r_full <= 1'b0;
            end
            if (o_take) begin
                if (i_item.last) begin
                    r_tsize   <= '0;
                    r_strings <= '0;
                    r_done    <= 1'b0;
                    r_funcs   <= '0;
                end else begin
                    r_tsize   <= n_tsize;
                    r_strings <= n_strings;
                    r_done    <= n_done;
                    r_funcs   <= n_funcs;
                end
            end
        end
    end

endmodule
`default_nettype wire

[src/iff_script_chunk_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iff_script_chunk_parser
// Byte-wise parser of a script container that tags every byte.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: drive i_data_byte / i_last_byte with i_push; a transfer
//   happens on a rising edge with i_push high and o_full low.
//   Result channel: while o_empty is low the oldest result sits on the o_
//   result ports; a transfer happens on an edge with i_pop high.
//   Exactly one result per input byte, in order.
// Path: the framing front classifies a byte in the cycle of its transfer;
//   the byte then passes through the two-entry queue and the result register.
// Throughput: one byte per cycle while the receiver keeps popping; the
//   framing loop (phase, id/size shift and payload counters) updates on every transfer.
// Stall: when the receiver holds off pop, the result register and the
//   two-entry queue fill, then o_full rises; nothing is dropped.
// Reset: synchronous, active low; all parse state and queues clear.
//   A byte flagged last also returns the parse state to its reset value.
// ----------------------------------------------------------------------------
`default_nettype none
module iff_script_chunk_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    output logic             o_full,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_empty,
    input  wire logic        i_pop,
    output logic [2:0]       o_region,
    output logic [31:0]      o_payload_index,
    output logic             o_word_valid,
    output logic [15:0]      o_word_value,
    output logic [30:0]      o_word_index,
    output logic [31:0]      o_text_bytes,
    output logic [30:0]      o_string_count,
    output logic [30:0]      o_function_count,
    output logic             o_clean_end
);

    iffp_pkg::t_item   w_front_item;
    iffp_pkg::t_item   w_q_item;
    iffp_pkg::t_result w_res;
    logic w_q_empty;
    logic w_take;
    logic w_accept;

    // Front advances only on an actual transfer.
    assign w_accept = i_push && !o_full;

    iffp_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_data  (i_data_byte),
        .i_last  (i_last_byte),
        .o_item  (w_front_item)
    );

    iffp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_item  (w_front_item),
        .o_full  (o_full),
        .i_pop   (w_take),
        .o_empty (w_q_empty),
        .o_item  (w_q_item)
    );

    iffp_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_q_empty),
        .i_item  (w_q_item),
        .o_take  (w_take),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_res   (w_res)
    );

    assign o_region         = w_res.region;
    assign o_payload_index  = w_res.pidx;
    assign o_word_valid     = w_res.wvalid;
    assign o_word_value     = w_res.wvalue;
    assign o_word_index     = w_res.windex;
    assign o_text_bytes     = w_res.text_bytes;
    assign o_string_count   = w_res.strings;
    assign o_function_count = w_res.funcs;
    assign o_clean_end      = w_res.clean_end;

endmodule
`default_nettype wire
